@@ sv/brsc_pkg.sv @@
// ----------------------------------------------------------------------------
// brsc_pkg: shared types and constants of the bit reader
// Operation and status codes, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package brsc_pkg;

    localparam int BUFFER_BITS_DEF   = 32;
    localparam int MAX_READ_BITS_DEF = 24;
    localparam int BYTE_BITS         = 8;
    localparam int START_BITS        = 24;
    localparam int COUNT_W           = 5;
    localparam int STATUS_W          = 2;
    localparam logic [START_BITS-1:0] START_CODE = 24'h000001;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_READ = 2'd1,
        OP_SEEK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_FULL   = 2'd2,
        ST_SEARCH = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH
    } t_state;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_READ,
        ACT_ALIGN,
        ACT_DROP
    } t_act;

    typedef struct packed {
        logic    capture;
        t_act    act;
        logic    set_search;
        logic    clr_search;
        logic    out_load;
        t_status out_status;
        logic    out_found;
        logic    out_value_en;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic short_read;
        logic searching;
        logic ge3;
        logic top_is_start;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ sv/bit_reader_start_code_seek.sv @@
// ----------------------------------------------------------------------------
// bit_reader_start_code_seek: bit buffer reader with start code search
// Pushes stream bytes into a bit buffer, reads fields of up to
// MAX_READ_BITS bits and seeks the next 00 00 01 start code.
// ----------------------------------------------------------------------------
//
//  channel  handshake                  payload
//  -------  -------------------------  ---------------------------------------
//  in       i_in_valid / o_in_stall    i_op, i_data_byte, i_bit_count
//  out      o_out_valid / i_out_stall  o_value, o_status, o_start_found,
//                                      o_bits_held
//
// A push, a read or a no-op passes through the accept state and the execute
// state. A seek, and a push taken while a search is open, go on into the
// search loop, which drops one byte a cycle until the start code is at the top or fewer than three bytes remain.
// Items are handled one at a time; the input stalls until the result is in
// the output register. Reset is synchronous and clears the buffer.
// An output stall holds the result and delays only the next result load.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_reader_start_code_seek
    import brsc_pkg::*;
#(
    parameter int BUFFER_BITS   = BUFFER_BITS_DEF,
    parameter int MAX_READ_BITS = MAX_READ_BITS_DEF,
    localparam int HW = $clog2(BUFFER_BITS + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_op,
    input  wire logic [BYTE_BITS-1:0] i_data_byte,
    input  wire logic [COUNT_W-1:0]   i_bit_count,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [MAX_READ_BITS-1:0]  o_value,
    output logic [STATUS_W-1:0]       o_status,
    output logic                      o_start_found,
    output logic [HW-1:0]             o_bits_held
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    brsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    brsc_dp #(
        .BUFFER_BITS   (BUFFER_BITS),
        .MAX_READ_BITS (MAX_READ_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .i_bit_count   (i_bit_count),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_value       (o_value),
        .o_status      (o_status),
        .o_start_found (o_start_found),
        .o_bits_held   (o_bits_held)
    );

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_start_found) |-> (o_status == ST_OK))
        else $error("start code reported with a non-ok status");

endmodule

`default_nettype wire

@@ sv/brsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// brsc_ctrl: bit reader controller
// Sequences one item at a time: capture, execute, byte-wise start code
// search, and hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brsc_ctrl
    import brsc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire logic     i_out_stall,
    output logic          o_out_valid,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    w_out_free;
    t_dp_cmd w_cmd;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_cmd            = '0;
        w_cmd.act        = ACT_NONE;
        w_cmd.out_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                unique case (i_stat.op)
                    OP_PUSH: begin
                        if (i_stat.full) begin
                            w_cmd.out_load   = w_out_free;
                            w_cmd.out_status = ST_FULL;
                        end else if (i_stat.searching) begin
                            // The byte goes in now; the search decides the result.
                            w_cmd.act = ACT_PUSH;
                        end else if (w_out_free) begin
                            w_cmd.act      = ACT_PUSH;
                            w_cmd.out_load = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (w_out_free) begin
                            w_cmd.act          = ACT_READ;
                            w_cmd.clr_search   = 1'b1;
                            w_cmd.out_load     = 1'b1;
                            w_cmd.out_status   = i_stat.short_read ? ST_SHORT : ST_OK;
                            w_cmd.out_value_en = !i_stat.short_read;
                        end
                    end
                    OP_SEEK: begin
                        w_cmd.act = ACT_ALIGN;
                    end
                    OP_NONE: begin
                        w_cmd.out_load = w_out_free;
                    end
                    default: begin
                        w_cmd.out_load = w_out_free;
                    end
                endcase
            end
            S_SEARCH: begin
                if (!i_stat.ge3) begin
                    w_cmd.set_search = w_out_free;
                    w_cmd.out_load   = w_out_free;
                    w_cmd.out_status = ST_SEARCH;
                end else if (i_stat.top_is_start) begin
                    w_cmd.clr_search = w_out_free;
                    w_cmd.out_load   = w_out_free;
                    w_cmd.out_found  = 1'b1;
                end else begin
                    w_cmd.act = ACT_DROP;
                end
            end
            default: begin
                w_cmd.capture = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_cmd.out_load) begin
                    n_state = S_IDLE;
                end else if (w_cmd.act == ACT_PUSH || w_cmd.act == ACT_ALIGN) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_cmd.out_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = w_cmd.out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_EXEC))
        else $error("accepted beat did not start execution");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_out_free)
        else $error("result loaded over a beat still waiting");

endmodule

`default_nettype wire

@@ sv/brsc_dp.sv @@
// ----------------------------------------------------------------------------
// brsc_dp: bit reader datapath
// Bit buffer, held-bit count, search flag, one shared extraction shifter and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brsc_dp
    import brsc_pkg::*;
#(
    parameter int BUFFER_BITS   = BUFFER_BITS_DEF,
    parameter int MAX_READ_BITS = MAX_READ_BITS_DEF,
    localparam int HW = $clog2(BUFFER_BITS + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [1:0]               i_op,
    input  wire logic [BYTE_BITS-1:0]     i_data_byte,
    input  wire logic [COUNT_W-1:0]       i_bit_count,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    output logic [MAX_READ_BITS-1:0]      o_value,
    output logic [STATUS_W-1:0]           o_status,
    output logic                          o_start_found,
    output logic [HW-1:0]                 o_bits_held
);

    localparam int CW = $clog2(MAX_READ_BITS + 1);

    logic [BUFFER_BITS-1:0]   r_buf, n_buf, w_pre;
    logic [HW-1:0]            r_held, n_held;
    logic                     r_search;
    t_op                      r_op;
    logic [BYTE_BITS-1:0]     r_byte;
    logic [COUNT_W-1:0]       r_cnt;
    logic [MAX_READ_BITS-1:0] r_value;
    t_status                  r_status;
    logic                     r_found;
    logic [HW-1:0]            r_held_out;

    logic [CW-1:0]            w_nsat;
    logic                     w_short;
    logic [HW-1:0]            w_sh;
    logic [BUFFER_BITS-1:0]   w_shifted;
    logic [MAX_READ_BITS-1:0] w_value;

    // A read count beyond the maximum saturates.
    always_comb begin
        if (int'(r_cnt) > MAX_READ_BITS) begin
            w_nsat = CW'(MAX_READ_BITS);
        end else begin
            w_nsat = CW'(r_cnt);
        end
    end

    assign w_short = HW'(w_nsat) > r_held;

    // One shifter serves both the read field and the start code window.
    assign w_sh      = (r_op == OP_READ) ? (r_held - HW'(w_nsat))
                                         : (r_held - HW'(START_BITS));
    assign w_shifted = r_buf >> w_sh;
    assign w_value   = w_shifted[MAX_READ_BITS-1:0]
                     & ~({MAX_READ_BITS{1'b1}} << w_nsat);

    always_comb begin
        w_pre = r_buf;
        unique case (i_cmd.act)
            ACT_NONE:  n_held = r_held;
            ACT_PUSH: begin
                n_held = r_held + HW'(BYTE_BITS);
                w_pre  = {r_buf[BUFFER_BITS-BYTE_BITS-1:0], r_byte};
            end
            ACT_READ:  n_held = w_short ? r_held : (r_held - HW'(w_nsat));
            ACT_ALIGN: n_held = r_held & ~HW'(BYTE_BITS - 1);
            ACT_DROP:  n_held = r_held - HW'(BYTE_BITS);
            default:   n_held = r_held;
        endcase
        // Bits above the held count are kept zero.
        n_buf = w_pre & ~({BUFFER_BITS{1'b1}} << n_held);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_held   <= '0;
            r_search <= 1'b0;
        end else begin
            r_buf  <= n_buf;
            r_held <= n_held;
            if (i_cmd.set_search) begin
                r_search <= 1'b1;
            end else if (i_cmd.clr_search) begin
                r_search <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_op);
            r_byte <= i_data_byte;
            r_cnt  <= i_bit_count;
        end
        if (i_cmd.out_load) begin
            r_value    <= i_cmd.out_value_en ? w_value : '0;
            r_status   <= i_cmd.out_status;
            r_found    <= i_cmd.out_found;
            r_held_out <= n_held;
        end
    end

    assign o_stat.op           = r_op;
    assign o_stat.full         = r_held > HW'(BUFFER_BITS - BYTE_BITS);
    assign o_stat.short_read   = w_short;
    assign o_stat.searching    = r_search;
    assign o_stat.ge3          = r_held >= HW'(START_BITS);
    assign o_stat.top_is_start = (w_shifted[START_BITS-1:0] == START_CODE);

    assign o_value       = r_value;
    assign o_status      = r_status;
    assign o_start_found = r_found;
    assign o_bits_held   = r_held_out;

    a_clean_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buf & ({BUFFER_BITS{1'b1}} << r_held)) == '0)
        else $error("bits above the held count are not zero");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(BUFFER_BITS))
        else $error("held count exceeds the buffer size");

endmodule

`default_nettype wire

@@ tb/brsc_checker.sv @@
// ----------------------------------------------------------------------------
// brsc_checker: scoreboard for the bit reader with start code seek
// Watches both channels of the bit reader, keeps its own copy of the bit
// buffer, works out the result of every accepted input beat and compares
// each accepted output beat with the oldest outstanding result.
// ----------------------------------------------------------------------------
`default_nettype none

module brsc_checker
    import brsc_pkg::*;
#(
    parameter int BUFFER_BITS   = BUFFER_BITS_DEF,
    parameter int MAX_READ_BITS = MAX_READ_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [1:0]           i_op,
    input  wire logic [BYTE_BITS-1:0] i_data_byte,
    input  wire logic [COUNT_W-1:0]   i_bit_count,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [23:0]          i_value,
    input  wire logic [STATUS_W-1:0]  i_status,
    input  wire logic                 i_start_found,
    input  wire logic [5:0]           i_bits_held,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_starts
);

    typedef struct packed {
        logic [23:0] value;
        t_status     status;
        logic        found;
        logic [5:0]  held;
    } t_reader_result;

    t_reader_result reader_results[$];

    logic [63:0] bits_buf;
    int unsigned held_bits;
    logic        seek_open;
    int          errors;
    int          pending;
    int          checked;
    int          starts;

    assign o_errors  = errors;
    assign o_pending = pending;
    assign o_checked = checked;
    assign o_starts  = starts;

    initial begin
        errors  = 0;
        pending = 0;
        checked = 0;
        starts  = 0;
    end

    function automatic logic [63:0] keep_low(input int unsigned n);
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // Drops whole bytes until the oldest three held bytes are the start code or fewer than three bytes are held.
    function automatic logic hunt_start_code();
        while (held_bits >= 3 * BYTE_BITS) begin
            if (((bits_buf >> (held_bits - 3 * BYTE_BITS)) & 64'hFF_FFFF) == 64'(START_CODE)) begin
                seek_open = 1'b0;
                return 1'b1;
            end
            held_bits -= BYTE_BITS;
            bits_buf &= keep_low(held_bits);
        end
        seek_open = 1'b1;
        return 1'b0;
    endfunction

    task automatic step_bit_reader(input t_op op, input logic [7:0] b, input logic [4:0] count);
        t_reader_result r;
        int unsigned    n;
        r.value  = '0;
        r.status = ST_OK;
        r.found  = 1'b0;
        n        = count;
        case (op)
            OP_PUSH: begin
                if (held_bits + BYTE_BITS > BUFFER_BITS) begin
                    r.status = ST_FULL;
                end else begin
                    bits_buf = ((bits_buf << BYTE_BITS) | 64'(b)) & keep_low(BUFFER_BITS);
                    held_bits += BYTE_BITS;
                    if (seek_open) begin
                        if (hunt_start_code())
                            r.found = 1'b1;
                        else
                            r.status = ST_SEARCH;
                    end
                end
            end
            OP_READ: begin
                // A read always abandons an open search.
                seek_open = 1'b0;
                if (n > MAX_READ_BITS)
                    n = MAX_READ_BITS;
                if (n > held_bits) begin
                    r.status = ST_SHORT;
                end else if (n > 0) begin
                    r.value = 24'((bits_buf >> (held_bits - n)) & keep_low(n));
                    held_bits -= n;
                    bits_buf &= keep_low(held_bits);
                end
            end
            OP_SEEK: begin
                held_bits -= held_bits % BYTE_BITS;
                bits_buf &= keep_low(held_bits);
                if (hunt_start_code())
                    r.found = 1'b1;
                else
                    r.status = ST_SEARCH;
            end
            default: begin
            end
        endcase
        r.held = 6'(held_bits);
        reader_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic compare_beat();
        t_reader_result r;
        if (reader_results.size() == 0) begin
            $display("%0t: output beat with no result outstanding, value %0h status %0d",
                     $time, i_value, i_status);
            errors++;
        end else begin
            r = reader_results.pop_front();
            check_field("value", 32'(r.value), 32'(i_value));
            check_field("status", 32'(r.status), 32'(i_status));
            check_field("start_found", 32'(r.found), 32'(i_start_found));
            check_field("bits_held", 32'(r.held), 32'(i_bits_held));
            checked++;
            if (r.found)
                starts++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bits_buf  = '0;
            held_bits = 0;
            seek_open = 1'b0;
            reader_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                step_bit_reader(t_op'(i_op), i_data_byte, i_bit_count);
            if (i_out_valid && !i_out_stall)
                compare_beat();
        end
        pending = reader_results.size();
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for bit_reader_start_code_seek
// Drives pushes, reads and seeks with random gaps and output stalls, first a
// short directed sequence and then random scenes built around start codes.
// A checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import brsc_pkg::*;

    localparam int TOTAL_ITEMS = 1075;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN       = 16;
    // The limit leaves a wide margin over the slowest items with their gaps and
    // output stalls, and over the two long holds.
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  in_op;
    logic [7:0]  in_byte;
    logic [4:0]  in_count;
    logic        out_valid;
    logic        out_stall;
    logic [23:0] out_value;
    logic [1:0]  out_status;
    logic        out_found;
    logic [5:0]  out_held;

    int errors;
    int pending;
    int checked;
    int starts;
    int items_sent;
    int cycle_count;
    bit steady;
    bit hold_request;

    bit_reader_start_code_seek uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_op          (in_op),
        .i_data_byte   (in_byte),
        .i_bit_count   (in_count),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_value       (out_value),
        .o_status      (out_status),
        .o_start_found (out_found),
        .o_bits_held   (out_held)
    );

    brsc_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_op          (in_op),
        .i_data_byte   (in_byte),
        .i_bit_count   (in_count),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_value       (out_value),
        .i_status      (out_status),
        .i_start_found (out_found),
        .i_bits_held   (out_held),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_starts      (starts)
    );

    initial clk = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_op(input t_op op, input logic [7:0] b, input logic [4:0] n);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_byte  <= b;
        in_count <= n;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        send_op(OP_PUSH, b, 5'($urandom_range(0, 31)));
    endtask

    task automatic read_bits(input logic [4:0] n);
        send_op(OP_READ, 8'($urandom_range(0, 255)), n);
    endtask

    task automatic seek_start();
        send_op(OP_SEEK, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
    endtask

    // Bytes leaning toward 00 and 01 so that start codes and near misses occur.
    function automatic logic [7:0] stream_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'h00;
        if (r < 6)
            return 8'h01;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [4:0] field_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 5'd0;
        if (r == 1)
            return 5'($urandom_range(25, 31));
        return 5'($urandom_range(1, 24));
    endfunction

    task automatic random_item(input bit wild);
        int r;
        if (wild) begin
            send_op(t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    5'($urandom_range(0, 31)));
        end else begin
            r = $urandom_range(0, 9);
            if (r < 5)
                push_byte(stream_byte());
            else if (r < 8)
                read_bits(field_len());
            else
                seek_start();
        end
    endtask

    task automatic random_scene();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: begin
                repeat ($urandom_range(1, 6)) random_item(1'b0);
            end
            3, 4: begin
                // Seek, then feed a few bytes followed by a start code.
                seek_start();
                repeat ($urandom_range(0, 3)) push_byte(stream_byte());
                push_byte(8'h00);
                push_byte(8'h00);
                push_byte(8'h01);
                repeat ($urandom_range(1, 3)) read_bits(field_len());
            end
            5: begin
                repeat ($urandom_range(4, 6)) push_byte(8'($urandom_range(0, 255)));
            end
            6: begin
                repeat ($urandom_range(2, 5)) read_bits(field_len());
            end
            7: begin
                seek_start();
                push_byte(stream_byte());
                if ($urandom_range(0, 1))
                    seek_start();
                else
                    read_bits(field_len());
                push_byte(stream_byte());
            end
            default: begin
                repeat ($urandom_range(1, 4)) random_item(1'b1);
            end
        endcase
    endtask

    task automatic run_directed();
        read_bits(5'd8);
        read_bits(5'd0);
        send_op(OP_NONE, 8'hFF, 5'd31);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h80);
        push_byte(8'h7F);
        push_byte(8'h55);
        read_bits(5'd31);
        read_bits(5'd1);
        read_bits(5'd7);
        push_byte(8'h00);
        seek_start();
        push_byte(8'h00);
        push_byte(8'h01);
        read_bits(5'd24);
        push_byte(8'hAB);
        read_bits(5'd3);
        seek_start();
        push_byte(8'h12);
        read_bits(5'd4);
        seek_start();
        seek_start();
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
    endtask

    // Output side: a random stall before each beat, and a long hold on request.
    initial begin
        int w;
        out_stall <= 1'b0;
        wait (rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            w = steady ? 0 : $urandom_range(0, 4);
            if (w > 0) begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        bit first_hold;
        bit second_hold;
        bit paused;
        first_hold   = 1'b0;
        second_hold  = 1'b0;
        paused       = 1'b0;
        items_sent   = 0;
        steady       = 1'b0;
        hold_request = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_op    <= OP_NONE;
        in_byte  <= '0;
        in_count <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        while (items_sent < TOTAL_ITEMS) begin
            if (!first_hold && items_sent >= 300) begin
                first_hold   = 1'b1;
                hold_request = 1'b1;
            end
            if (!second_hold && items_sent >= 850) begin
                second_hold  = 1'b1;
                hold_request = 1'b1;
            end
            if (!paused && items_sent >= 650) begin
                // Let the block run dry before going on.
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
            end
            steady = (items_sent >= 450 && items_sent < 560);
            random_scene();
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d items and checked %0d result beats, %0d of them completing a seek,",
                 items_sent, checked, starts);
        $display("with random gaps, two long output holds and one full drain pause.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
